### hdl/tffs_pkg.sv
// Shared types, constants and saturating helpers for the thin-film flux stencil.
// Used by tffs_mul, the top level and tffs_chk; depends on nothing.
package tffs_pkg;

  localparam int unsigned WW        = 63;  // wide intermediate, holds +-2^61
  localparam int unsigned BMAG_W    = 34;  // bits of |6B|
  localparam int unsigned MUL_LAT   = 3;   // cycles through tffs_mul
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FLUX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VDW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPUL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EN    = 3'd4;

  typedef logic signed [WW-1:0] wide_t;

  localparam wide_t WIDE_LIM = 63'sd2305843009213693952;

  typedef struct packed {
    logic [30:0]        height_minus2;
    logic [30:0]        height_minus1;
    logic [30:0]        height_center;
    logic [30:0]        height_plus1;
    logic [30:0]        height_plus2;
    logic [30:0]        mobility_minus1;
    logic [30:0]        mobility_center;
    logic [30:0]        mobility_plus1;
    logic signed [31:0] noise_left;
    logic signed [31:0] noise_right;
  } in_t;

  typedef struct packed {
    logic signed [31:0] rhs_value;
    logic               saturated_flag;
  } out_t;

  typedef struct packed {
    wide_t val;
    logic  sat;
  } sat_t;

  // per-site values that ride along the divider latency
  typedef struct packed {
    logic signed [31:0] d_right;   // h+1 - h0
    logic signed [31:0] d_left;    // h0 - h-1
    logic signed [31:0] noise;     // (n_right - n_left)/2
    logic [30:0]        h0;
    logic               zero_div;
  } side_t;

  function automatic sat_t add_sat(wide_t a, wide_t b);
    logic signed [WW:0] s;
    logic signed [WW:0] lim;
    sat_t r;
    s   = $signed({a[WW-1], a}) + $signed({b[WW-1], b});
    lim = $signed({1'b0, WIDE_LIM});
    r.sat = 1'b0;
    if (s > lim) begin
      r.val = WIDE_LIM;
      r.sat = 1'b1;
    end else if (s < -lim) begin
      r.val = -WIDE_LIM;
      r.sat = 1'b1;
    end else begin
      r.val = s[WW-1:0];
    end
    return r;
  endfunction

  function automatic out_t sat_out(wide_t v, logic sat_in);
    out_t r;
    r.saturated_flag = sat_in;
    if (v > wide_t'(32'sh7fffffff)) begin
      r.rhs_value      = 32'sh7fffffff;
      r.saturated_flag = 1'b1;
    end else if (v < wide_t'(-33'sh80000000)) begin
      r.rhs_value      = -32'sh80000000;
      r.saturated_flag = 1'b1;
    end else begin
      r.rhs_value = v[31:0];
    end
    return r;
  endfunction

endpackage

### hdl/tffs_mul.sv
// Three-stage signed fixed-point multiplier: magnitude, split partial products,
// then shift by FRAC_BITS, saturate to +-2^61 and restore sign. Uses tffs_pkg.
module tffs_mul #(
  parameter int unsigned AW        = 32,
  parameter int unsigned BW        = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic signed [AW-1:0]   a_i,
  input  logic signed [BW-1:0]   b_i,
  input  logic                   flag_i,
  output tffs_pkg::wide_t        prod_o,
  output logic                   sat_o
);

  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned XW = (PW > tffs_pkg::WW + 1) ? PW : tffs_pkg::WW + 1;

  logic [AW-1:0]    amag_q;
  logic [BW-1:0]    bmag_q;
  logic             neg1_q, flag1_q;
  logic [AW+BL-1:0] plo_q;
  logic [AW+BH-1:0] phi_q;
  logic             neg2_q, flag2_q;
  logic [PW-1:0]    full;
  logic [XW-1:0]    shx;
  logic [tffs_pkg::WW-1:0] mag;
  logic             ovf;

  always_ff @(posedge clk_i) begin
    amag_q  <= a_i[AW-1] ? $unsigned(-a_i) : $unsigned(a_i);
    bmag_q  <= b_i[BW-1] ? $unsigned(-b_i) : $unsigned(b_i);
    neg1_q  <= a_i[AW-1] ^ b_i[BW-1];
    flag1_q <= flag_i;
    plo_q   <= amag_q * bmag_q[BL-1:0];
    phi_q   <= amag_q * bmag_q[BW-1:BL];
    neg2_q  <= neg1_q;
    flag2_q <= flag1_q;
  end

  always_comb begin
    full = PW'(plo_q) + (PW'(phi_q) << BL);
    shx  = XW'(full >> FRAC_BITS);
    ovf  = shx > XW'(tffs_pkg::WIDE_LIM);
    mag  = ovf ? tffs_pkg::WIDE_LIM : shx[tffs_pkg::WW-1:0];
  end

  always_ff @(posedge clk_i) begin
    prod_o <= neg2_q ? -$signed(mag) : $signed(mag);
    sat_o  <= ovf | flag2_q;
  end

endmodule

### hdl/tffs_div.sv
// Pipelined restoring divider, one quotient bit per stage, NW stages.
// Stand-alone; no package use.
module tffs_div #(
  parameter int unsigned NW = 50,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  // numerator bits shift out the top while quotient bits shift in below
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rem_in, den_in;
    logic [DW:0]   trial;
    logic          ge;
    if (k == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end
    assign trial = {rem_in, nq_in[NW-1]};
    assign ge    = trial >= {1'b0, den_in};
    always_ff @(posedge clk_i) begin
      nq_q[k]  <= {nq_in[NW-2:0], ge};
      rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      den_q[k] <= den_in;
    end
  end

  assign quo_o = nq_q[NW-1];

endmodule

### hdl/thin_film_flux_stencil.sv
// Thin-film flux stencil top level: config registers, flux and van der Waals paths.
// Depends on tffs_pkg, tffs_mul and tffs_div.
//
//  channel   direction  handshake                  payload
//  command   in         start (accepted, busy low)  in_i     (tffs_pkg::in_t)
//  result    out        done_o, one-cycle strobe   result_o (tffs_pkg::out_t)
//  config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One site per clock; the two restoring dividers have 34 + FRAC_BITS stages each,
// one quotient bit per stage.
// busy stays low: the pipeline never stalls and the receiver cannot hold results off.
// Reset clears vld_q, res_q and config (en_q sets to 1); other flops are not reset.
// Change config only with no transaction in flight.
module thin_film_flux_stencil #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  tffs_pkg::in_t                      in_i,
  output logic                               done_o,
  output tffs_pkg::out_t                     result_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tffs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);

  localparam int unsigned QW       = tffs_pkg::BMAG_W + FRAC_BITS;
  localparam int unsigned CW       = QW + 2;
  localparam int unsigned LD       = QW;
  localparam int unsigned ML       = tffs_pkg::MUL_LAT;
  localparam int unsigned SIDE_LEN = LD + 3 + 2 * ML;
  localparam int unsigned PIPE_LEN = LD + 5 + 2 * ML;

  // config registers
  logic [30:0]        flux_q, vdw_q;
  logic signed [31:0] attr_q, repul_q;
  logic               en_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flux_q  <= '0;
      vdw_q   <= '0;
      attr_q  <= '0;
      repul_q <= '0;
      en_q    <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tffs_pkg::CFG_FLUX:  flux_q  <= cfg_data_i[30:0];
        tffs_pkg::CFG_VDW:   vdw_q   <= cfg_data_i[30:0];
        tffs_pkg::CFG_ATTR:  attr_q  <= $signed(cfg_data_i);
        tffs_pkg::CFG_REPUL: repul_q <= $signed(cfg_data_i);
        tffs_pkg::CFG_EN:    en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // constants derived from config
  logic [31:0]              b_abs;
  logic [tffs_pkg::BMAG_W-1:0] b6;
  logic [QW-1:0]            numer;
  logic signed [32:0]       two_a;

  always_comb begin
    b_abs = repul_q[31] ? $unsigned(-repul_q) : $unsigned(repul_q);
    b6    = (tffs_pkg::BMAG_W'(b_abs) << 2) + (tffs_pkg::BMAG_W'(b_abs) << 1);
    numer = {b6, {FRAC_BITS{1'b0}}};
    two_a = {attr_q, 1'b0};
  end

  // valid chain
  logic [PIPE_LEN-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LEN-2:0], start & ~busy};
    end
  end

  // stage 0: stencil differences, mobility averages, divisors
  logic signed [34:0] e_hm2, e_hm1, e_h0, e_hp1, e_hp2;
  logic signed [32:0] ndiff, nadj;
  logic [31:0]        sr_d, sl_d;
  tffs_pkg::side_t    side_d;

  logic [30:0]        mr_q, ml_q;
  logic signed [34:0] dr_q, dl_q;
  logic [31:0]        sr_q, sl_q;
  tffs_pkg::side_t    side_q;

  always_comb begin
    e_hm2 = $signed({4'b0, in_i.height_minus2});
    e_hm1 = $signed({4'b0, in_i.height_minus1});
    e_h0  = $signed({4'b0, in_i.height_center});
    e_hp1 = $signed({4'b0, in_i.height_plus1});
    e_hp2 = $signed({4'b0, in_i.height_plus2});
    sr_d  = 32'(in_i.height_plus1) + 32'(in_i.height_center);
    sl_d  = 32'(in_i.height_minus1) + 32'(in_i.height_center);
    ndiff = 33'(in_i.noise_right) - 33'(in_i.noise_left);
    // truncate toward zero
    nadj  = ndiff + $signed({32'd0, ndiff[32]});
    side_d.d_right  = $signed({1'b0, in_i.height_plus1}) - $signed({1'b0, in_i.height_center});
    side_d.d_left   = $signed({1'b0, in_i.height_center}) - $signed({1'b0, in_i.height_minus1});
    side_d.noise    = nadj[32:1];
    side_d.h0       = in_i.height_center;
    side_d.zero_div = (sr_d == '0) || (sl_d == '0);
  end

  always_ff @(posedge clk_i) begin
    mr_q   <= 31'((32'(in_i.mobility_center) + 32'(in_i.mobility_plus1)) >> 1);
    ml_q   <= 31'((32'(in_i.mobility_minus1) + 32'(in_i.mobility_center)) >> 1);
    dr_q   <= e_hp2 - (e_hp1 + (e_hp1 <<< 1)) + (e_h0 + (e_h0 <<< 1)) - e_hm1;
    dl_q   <= e_hp1 - (e_h0 + (e_h0 <<< 1)) + (e_hm1 + (e_hm1 <<< 1)) - e_hm2;
    sr_q   <= sr_d;
    sl_q   <= sl_d;
    side_q <= side_d;
  end

  // side data delay line
  tffs_pkg::side_t side_dly_q [SIDE_LEN];
  always_ff @(posedge clk_i) begin
    side_dly_q[0] <= side_q;
    for (int k = 1; k < SIDE_LEN; k++) begin
      side_dly_q[k] <= side_dly_q[k-1];
    end
  end

  // flux path
  tffs_pkg::wide_t pr, pl, pk;
  logic            pr_sat, pl_sat, pk_sat;
  tffs_pkg::sat_t  fx, ra;
  tffs_pkg::wide_t fx_q;
  logic            flux_sat_q;
  tffs_pkg::sat_t  ra_q;

  tffs_mul #(.AW(32), .BW(35), .FRAC_BITS(FRAC_BITS)) u_mul_r (
    .clk_i, .a_i($signed({1'b0, mr_q})), .b_i(dr_q), .flag_i(1'b0),
    .prod_o(pr), .sat_o(pr_sat)
  );
  tffs_mul #(.AW(32), .BW(35), .FRAC_BITS(FRAC_BITS)) u_mul_l (
    .clk_i, .a_i($signed({1'b0, ml_q})), .b_i(dl_q), .flag_i(1'b0),
    .prod_o(pl), .sat_o(pl_sat)
  );

  assign fx = tffs_pkg::add_sat(pr, -pl);

  always_ff @(posedge clk_i) begin
    fx_q       <= fx.val;
    flux_sat_q <= fx.sat | pr_sat | pl_sat;
  end

  tffs_mul #(.AW(32), .BW(tffs_pkg::WW), .FRAC_BITS(FRAC_BITS)) u_mul_k (
    .clk_i, .a_i($signed({1'b0, flux_q})), .b_i(fx_q), .flag_i(flux_sat_q),
    .prod_o(pk), .sat_o(pk_sat)
  );

  assign ra = tffs_pkg::add_sat(tffs_pkg::wide_t'(side_dly_q[2*ML].h0), -pk);

  always_ff @(posedge clk_i) begin
    ra_q.val <= ra.val;
    ra_q.sat <= ra.sat | pk_sat;
  end

  // hold the flux result until the van der Waals term arrives
  tffs_pkg::sat_t ra_dly_q [LD];
  always_ff @(posedge clk_i) begin
    ra_dly_q[0] <= ra_q;
    for (int k = 1; k < LD; k++) begin
      ra_dly_q[k] <= ra_dly_q[k-1];
    end
  end

  // van der Waals path
  logic [QW-1:0]      quo_r, quo_l;
  logic signed [CW-1:0] qs_r, qs_l;
  logic signed [CW-1:0] cr_q, cl_q;
  logic signed [31:0] dr_c_q, dl_c_q;

  tffs_div #(.NW(QW), .DW(32)) u_div_r (
    .clk_i, .num_i(numer), .den_i(sr_q), .quo_o(quo_r)
  );
  tffs_div #(.NW(QW), .DW(32)) u_div_l (
    .clk_i, .num_i(numer), .den_i(sl_q), .quo_o(quo_l)
  );

  always_comb begin
    qs_r = $signed({2'b00, quo_r});
    qs_l = $signed({2'b00, quo_l});
    if (repul_q[31]) begin
      qs_r = -qs_r;
      qs_l = -qs_l;
    end
  end

  always_ff @(posedge clk_i) begin
    cr_q   <= qs_r - CW'(two_a);
    cl_q   <= qs_l - CW'(two_a);
    dr_c_q <= side_dly_q[LD-1].d_right;
    dl_c_q <= side_dly_q[LD-1].d_left;
  end

  tffs_pkg::wide_t pcr, pcl, pv;
  logic            pcr_sat, pcl_sat, pv_sat;
  tffs_pkg::sat_t  vs;
  tffs_pkg::wide_t v_q;
  logic            v_sat_q;

  tffs_mul #(.AW(32), .BW(CW), .FRAC_BITS(FRAC_BITS)) u_mul_cr (
    .clk_i, .a_i(dr_c_q), .b_i(cr_q), .flag_i(1'b0), .prod_o(pcr), .sat_o(pcr_sat)
  );
  tffs_mul #(.AW(32), .BW(CW), .FRAC_BITS(FRAC_BITS)) u_mul_cl (
    .clk_i, .a_i(dl_c_q), .b_i(cl_q), .flag_i(1'b0), .prod_o(pcl), .sat_o(pcl_sat)
  );

  assign vs = tffs_pkg::add_sat(pcr, -pcl);

  always_ff @(posedge clk_i) begin
    v_q     <= vs.val;
    v_sat_q <= vs.sat | pcr_sat | pcl_sat;
  end

  tffs_mul #(.AW(32), .BW(tffs_pkg::WW), .FRAC_BITS(FRAC_BITS)) u_mul_v (
    .clk_i, .a_i($signed({1'b0, vdw_q})), .b_i(v_q), .flag_i(v_sat_q),
    .prod_o(pv), .sat_o(pv_sat)
  );

  // combine
  tffs_pkg::sat_t  s1, s2;
  tffs_pkg::wide_t r1_q;
  logic            sat1_q;
  tffs_pkg::side_t sd;
  tffs_pkg::out_t  res_d, res_q;

  assign s1 = tffs_pkg::add_sat(ra_dly_q[LD-1].val, pv);

  always_ff @(posedge clk_i) begin
    if (en_q) begin
      r1_q   <= s1.val;
      sat1_q <= ra_dly_q[LD-1].sat | s1.sat | pv_sat;
    end else begin
      r1_q   <= ra_dly_q[LD-1].val;
      sat1_q <= ra_dly_q[LD-1].sat;
    end
  end

  always_comb begin
    sd = side_dly_q[SIDE_LEN-1];
    s2 = tffs_pkg::add_sat(r1_q, tffs_pkg::wide_t'(sd.noise));
    if (en_q && sd.zero_div) begin
      res_d.rhs_value      = repul_q[31] ? -32'sh80000000 : 32'sh7fffffff;
      res_d.saturated_flag = 1'b1;
    end else if (en_q) begin
      res_d = tffs_pkg::sat_out(s2.val, sat1_q | s2.sat);
    end else begin
      res_d = tffs_pkg::sat_out(r1_q, sat1_q);
    end
  end

  // load only on a valid transaction so the result holds between strobes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (vld_q[PIPE_LEN-2]) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;
  assign done_o   = vld_q[PIPE_LEN-1];

endmodule

### hdl/tffs_chk.sv
// Port-level checks for the thin-film flux stencil: fixed latency, result hold.
// Depends on tffs_pkg; bound to thin_film_flux_stencil.
module tffs_chk #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           done_o,
  input tffs_pkg::out_t                 result_o
);

  localparam int unsigned LAT = tffs_pkg::BMAG_W + FRAC_BITS + 5 + 2 * tffs_pkg::MUL_LAT;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("accepted transaction gave no result at fixed latency");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without matching accepted transaction");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(result_o))
    else $error("result changed without a strobe");

endmodule

bind thin_film_flux_stencil tffs_chk #(.FRAC_BITS(FRAC_BITS)) u_tffs_chk (.*);
